/* design/tphi_pkg.sv */
// ---------------------------------------------------------------------------
// tphi_pkg
// Shared types and constants for the timestamped position history block.
// ---------------------------------------------------------------------------
`default_nettype none

package tphi_pkg;

    localparam int HIST_DEPTH = 32;
    localparam int IDX_W      = $clog2(HIST_DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int STAMP_W    = 48;
    localparam int POS_W      = 24;
    localparam int FRAC_BITS  = 16;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int MIN_SAMPLES = 2;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic [STAMP_W-1:0]      stamp_ms;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_z;
    } item_t;

    typedef struct packed {
        logic                    found;
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_z;
    } result_t;

    typedef struct packed {
        logic [STAMP_W-1:0]      stamp;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] z;
    } sample_t;

    localparam int SAMPLE_W = $bits(sample_t);

    // queue entry: classified item
    typedef struct packed {
        logic  is_query;
        item_t item;
    } work_t;

endpackage

`default_nettype wire

/* design/tphi_ram.sv */
// ---------------------------------------------------------------------------
// tphi_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tphi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* design/tphi_front.sv */
// ---------------------------------------------------------------------------
// tphi_front
// Input side: takes items, tags them record or query, and holds them in a
// two-entry queue for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tphi_front
    import tphi_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output      logic  item_stall,
    input  wire item_t item,
    output      logic  work_valid,
    output      work_t work,
    input  wire logic  work_pop
);

    work_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    work_t      entry;

    assign item_stall = (cnt_reg == 2'd2);
    assign push       = item_valid && !item_stall;
    assign pop        = work_pop && work_valid;
    assign work_valid = (cnt_reg != 2'd0);
    assign work       = q_reg[rd_ptr_reg];

    // classify
    always_comb
    begin
        entry.item     = item;
        entry.is_query = (item.mode == MODE_QUERY);
    end

    // pointers and fill
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

/* design/tphi_back.sv */
// ---------------------------------------------------------------------------
// tphi_back
// Execution side: writes records into the sample ring, walks the ring for
// queries, divides out the fraction bit-serially and interpolates.
// ---------------------------------------------------------------------------
`default_nettype none

module tphi_back
    import tphi_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    work_valid,
    input  wire work_t   work,
    output      logic    work_pop,
    output      logic    res_valid,
    input  wire logic    res_stall,
    output      result_t res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WAITA = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HIST_DEPTH);
    localparam logic [4:0]       DIV_LAST = 5'(FRAC_W - 1);

    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   wslot_reg, wslot_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [STAMP_W-1:0] qt_reg, qt_next;
    sample_t            a_reg, a_next;
    sample_t            b_reg, b_next;
    logic [STAMP_W:0]   rem_reg, rem_next;
    logic [STAMP_W-1:0] span_reg, span_next;
    logic [FRAC_W-1:0]  quo_reg, quo_next;
    logic [4:0]         dcnt_reg, dcnt_next;
    logic signed [42:0] px_reg, px_next;
    logic signed [42:0] pz_reg, pz_next;
    result_t            pend_reg, pend_next;
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_rd_addr;
    sample_t          ram_wdata, ram_rdata;
    logic [IDX_W-1:0] base;
    logic [CNT_W:0]   idx_plus2;
    logic [STAMP_W:0] rem_sub;
    logic             div_ge;
    logic signed [24:0] dx, dz;
    logic signed [26:0] sum_x, sum_z;
    logic             out_free;

    tphi_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HIST_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wslot_reg),
        .wr_data (ram_wdata),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rdata)
    );

    assign base      = (fill_reg == FULL_CNT) ? wslot_reg : '0;
    assign idx_plus2 = {1'b0, idx_reg} + (CNT_W+1)'(2);
    assign out_free  = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // divider step
    assign div_ge  = rem_reg >= {1'b0, span_reg};
    assign rem_sub = div_ge ? (rem_reg - {1'b0, span_reg}) : rem_reg;

    // interpolation terms
    assign dx    = 25'(b_reg.x) - 25'(a_reg.x);
    assign dz    = 25'(b_reg.z) - 25'(a_reg.z);
    assign sum_x = 27'(a_reg.x) + px_reg[42:16];
    assign sum_z = 27'(a_reg.z) + pz_reg[42:16];

    always_comb
    begin
        state_next     = state_reg;
        wslot_next     = wslot_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        qt_next        = qt_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        rem_next       = rem_reg;
        span_next      = span_reg;
        quo_next       = quo_reg;
        dcnt_next      = dcnt_reg;
        px_next        = px_reg;
        pz_next        = pz_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        work_pop       = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = '{stamp: work.item.stamp_ms, x: work.item.pos_x, z: work.item.pos_z};
        ram_rd_addr    = base;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (work_valid)
                begin
                    work_pop = 1'b1;
                    qt_next  = work.item.stamp_ms;
                    idx_next = '0;
                    if (!work.is_query)
                    begin
                        ram_we     = 1'b1;
                        wslot_next = wslot_reg + IDX_W'(1);
                        if (fill_reg != FULL_CNT)
                        begin
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                    else if (fill_reg < CNT_W'(MIN_SAMPLES))
                    begin
                        pend_next  = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        ram_rd_addr = base;
                        state_next  = ST_WAITA;
                    end
                end
            end

            ST_WAITA:
            begin
                a_next      = ram_rdata;
                ram_rd_addr = base + IDX_W'(1);
                state_next  = ST_CMP;
            end

            ST_CMP:
            begin
                if (qt_reg < a_reg.stamp)
                begin
                    pend_next  = '0;
                    state_next = ST_OUT;
                end
                else if (qt_reg <= ram_rdata.stamp)
                begin
                    b_next = ram_rdata;
                    if (ram_rdata.stamp == a_reg.stamp)
                    begin
                        pend_next  = '{found: 1'b1, out_x: a_reg.x, out_z: a_reg.z};
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        rem_next   = {1'b0, qt_reg - a_reg.stamp};
                        span_next  = ram_rdata.stamp - a_reg.stamp;
                        quo_next   = '0;
                        dcnt_next  = '0;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    a_next   = ram_rdata;
                    idx_next = idx_reg + CNT_W'(1);
                    if (idx_plus2 < {1'b0, fill_reg})
                    begin
                        ram_rd_addr = base + idx_plus2[IDX_W-1:0];
                    end
                    else
                    begin
                        pend_next  = '0;
                        state_next = ST_OUT;
                    end
                end
            end

            // one quotient bit per cycle, MSB first
            ST_DIV:
            begin
                rem_next  = {rem_sub[STAMP_W-1:0], 1'b0};
                quo_next  = {quo_reg[FRAC_W-2:0], div_ge};
                dcnt_next = dcnt_reg + 5'd1;
                if (dcnt_reg == DIV_LAST)
                begin
                    state_next = ST_MUL;
                end
            end

            // operands widened first so the product keeps all its bits
            ST_MUL:
            begin
                px_next    = 43'(dx) * 43'($signed({1'b0, quo_reg}));
                pz_next    = 43'(dz) * 43'($signed({1'b0, quo_reg}));
                state_next = ST_SUM;
            end

            ST_SUM:
            begin
                pend_next  = '{found: 1'b1, out_x: sum_x[POS_W-1:0], out_z: sum_z[POS_W-1:0]};
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (out_free)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wslot_reg     <= '0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wslot_reg     <= wslot_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        qt_reg   <= qt_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        rem_reg  <= rem_next;
        span_reg <= span_next;
        quo_reg  <= quo_next;
        dcnt_reg <= dcnt_next;
        px_reg   <= px_next;
        pz_reg   <= pz_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

/* design/timestamped_position_history_interp.sv */
// ---------------------------------------------------------------------------
// timestamped_position_history_interp
// Ring of the last 32 timestamped x/z positions with linear interpolation.
// ---------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): mode 0 records a sample,
//   mode 1 queries the position at stamp_ms. A transfer happens when
//   item_valid is high and item_stall is low.
//   res channel (res_valid / res_stall / res): one result per query, none
//   per record. found is 0 and the coordinates zero when history does not
//   cover the time.
//   A two-entry queue decouples intake from execution; a record is written
//   to the ring as it is popped. A query is set up, walks up to 31 ring
//   pairs (one RAM read each), divides out the fraction serially,
//   interpolates and loads the output register before the back end takes
//   the next queued item.
//   Reset empties the ring and the queue; stored samples are not cleared.
//   While res_stall is high the result is held, and the back end waits with
//   the next finished query; records still proceed until that point.
// ---------------------------------------------------------------------------
`default_nettype none

module timestamped_position_history_interp
    import tphi_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output      logic    item_stall,
    input  wire item_t   item,
    output      logic    res_valid,
    input  wire logic    res_stall,
    output      result_t res
);

    logic  work_valid;
    work_t work;
    logic  work_pop;

    tphi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .work_valid (work_valid),
        .work       (work),
        .work_pop   (work_pop)
    );

    tphi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (work_valid),
        .work       (work),
        .work_pop   (work_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule

`default_nettype wire

/* verif/timestamped_position_history_interp_tb.sv */
// ---------------------------------------------------------------------------
// timestamped_position_history_interp_tb
// Drives record and query transfers into the position history ring and
// checks every query result field by field against a built-in predictor.
// A directed table runs first, then random traffic with random idling.
// ---------------------------------------------------------------------------
`default_nettype none

module timestamped_position_history_interp_tb;
    import tphi_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    res_valid;
    logic    res_stall;
    result_t res;

    timestamped_position_history_interp dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    // predictor state
    sample_t           ring [HIST_DEPTH];
    int                next_slot;
    int                held;
    result_t           pending_q[$];
    int                mismatches;
    int                unexpected;
    bit                calm;

    // directed table: item, whether the result is typed in, that result
    typedef struct {
        item_t   it;
        bit      fixed;
        result_t want;
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = 1'b1;
            #10 clk = 1'b0;
        end
    end

    function automatic logic signed [POS_W-1:0] blend(
        logic signed [POS_W-1:0] a, logic signed [POS_W-1:0] b, longint f);
        longint p;
        longint t;
        begin
            p = (longint'(b) - longint'(a)) * f;
            t = p >>> FRAC_BITS;  // arithmetic shift floors
            return POS_W'(longint'(a) + t);
        end
    endfunction

    // position lookup at time q over the current ring
    function automatic result_t locate(logic [STAMP_W-1:0] q);
        result_t r;
        int      base;
        sample_t sa;
        sample_t sb;
        logic [STAMP_W-1:0] span;
        longint  f;
        logic [STAMP_W+FRAC_BITS-1:0] num;
        begin
            r = '0;
            if (held < MIN_SAMPLES)
                return r;
            base = (held >= HIST_DEPTH) ? next_slot : 0;
            for (int i = 0; i + 1 < held; i++)
            begin
                sa = ring[(base + i) % HIST_DEPTH];
                sb = ring[(base + i + 1) % HIST_DEPTH];
                if (q < sa.stamp)
                    return r;
                if (q <= sb.stamp)
                begin
                    span = sb.stamp - sa.stamp;
                    r.found = 1'b1;
                    if (span == 0)
                    begin
                        r.out_x = sa.x;
                        r.out_z = sa.z;
                    end
                    else
                    begin
                        num = {q - sa.stamp, 16'h0};
                        f = longint'(num / span);
                        r.out_x = blend(sa.x, sb.x, f);
                        r.out_z = blend(sa.z, sb.z, f);
                    end
                    return r;
                end
            end
            sa = ring[(base + held - 1) % HIST_DEPTH];
            if (q == sa.stamp)
            begin
                r.found = 1'b1;
                r.out_x = sa.x;
                r.out_z = sa.z;
            end
            return r;
        end
    endfunction

    function automatic void absorb(item_t it);
        begin
            if (it.mode == MODE_RECORD)
            begin
                ring[next_slot] = '{stamp: it.stamp_ms, x: it.pos_x, z: it.pos_z};
                next_slot = (next_slot + 1) % HIST_DEPTH;
                if (held < HIST_DEPTH)
                    held++;
            end
            else
                pending_q.push_back(locate(it.stamp_ms));
        end
    endfunction

    function automatic item_t mk(logic m, logic [STAMP_W-1:0] s,
                                 logic [POS_W-1:0] x, logic [POS_W-1:0] z);
        item_t it;
        begin
            it.mode = m;
            it.stamp_ms = s;
            it.pos_x = x;
            it.pos_z = z;
            return it;
        end
    endfunction

    function automatic item_t rand_item(logic [STAMP_W-1:0] s, logic m);
        return mk(m, s, POS_W'($urandom), POS_W'($urandom));
    endfunction

    // one transfer on the item channel, with random idle cycles;
    // valid stays high after the transfer until the next idle or the end
    task automatic send(item_t it);
        begin
            while (!calm && $urandom_range(99) < 34)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
            item_valid <= 1'b1;
            item <= it;
            @(posedge clk);
            while (item_stall)
                @(posedge clk);
            absorb(it);
        end
    endtask

    // result side: random stall, check each transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_q.size() == 0)
                begin
                    unexpected++;
                    if (mismatches + unexpected <= 10)
                        $display("unexpected result found=%0d x=%0d z=%0d",
                                 res.found, res.out_x, res.out_z);
                end
                else
                begin
                    result_t w;
                    w = pending_q.pop_front();
                    if (w.found !== res.found || w.out_x !== res.out_x
                        || w.out_z !== res.out_z)
                    begin
                        mismatches++;
                        if (mismatches + unexpected <= 10)
                            $display("mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     w.found, w.out_x, w.out_z,
                                     res.found, res.out_x, res.out_z);
                    end
                end
            end
            res_stall <= !calm && ($urandom_range(99) < 34);
        end
    end

    row_t plan[$];

    initial
    begin
        logic [STAMP_W-1:0] t;
        int                 n;
        int                 quiet;
        item_t              it;
        rst_n = 1'b0;
        item_valid = 1'b0;
        res_stall = 1'b0;
        item = '0;
        next_slot = 0;
        held = 0;
        mismatches = 0;
        unexpected = 0;
        calm = 1'b0;

        // directed: empty, one sample, extremes, equal stamps, edges
        plan.push_back('{mk(MODE_QUERY, 0, 0, 0), 1, '0});
        plan.push_back('{mk(MODE_RECORD, 100, 24'h7FFFFF, 24'h800000), 0, '0});
        plan.push_back('{mk(MODE_QUERY, 100, 0, 0), 1, '0});
        plan.push_back('{mk(MODE_RECORD, 200, 24'h800000, 24'h7FFFFF), 0, '0});
        plan.push_back('{mk(MODE_QUERY, 99, 0, 0), 1, '0});
        plan.push_back('{mk(MODE_QUERY, 100, 24'hFFFFFF, 24'hFFFFFF), 1,
                         '{1'b1, 24'h7FFFFF, 24'h800000}});
        plan.push_back('{mk(MODE_QUERY, 200, 0, 0), 1,
                         '{1'b1, 24'h800000, 24'h7FFFFF}});
        plan.push_back('{mk(MODE_QUERY, 150, 0, 0), 0, '0});
        plan.push_back('{mk(MODE_QUERY, 133, 0, 0), 0, '0});
        plan.push_back('{mk(MODE_QUERY, 201, 0, 0), 1, '0});
        plan.push_back('{mk(MODE_RECORD, 200, 24'h000100, 24'hFFFF00), 0, '0});
        plan.push_back('{mk(MODE_QUERY, 200, 0, 0), 0, '0});
        plan.push_back('{mk(MODE_RECORD, 48'hFFFFFFFFFFFF, 24'h000001, 24'hFFFFFF),
                         0, '0});
        plan.push_back('{mk(MODE_QUERY, 48'hFFFFFFFFFFFF, 0, 0), 1,
                         '{1'b1, 24'h000001, 24'hFFFFFF}});
        plan.push_back('{mk(MODE_QUERY, 48'h800000000000, 0, 0), 0, '0});
        plan.push_back('{mk(MODE_QUERY, 48'h7FFFFFFFFFFF, 0, 0), 0, '0});
        // unsorted: a drop below the previous stamp
        plan.push_back('{mk(MODE_RECORD, 50, 24'h123456, 24'h654321), 0, '0});
        plan.push_back('{mk(MODE_QUERY, 48'hFFFFFFFFFFFE, 0, 0), 0, '0});
        plan.push_back('{mk(MODE_QUERY, 75, 0, 0), 0, '0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            send(plan[i].it);
            if (plan[i].fixed && plan[i].it.mode == MODE_QUERY
                && pending_q[$] !== plan[i].want)
            begin
                mismatches++;
                if (mismatches + unexpected <= 10)
                    $display("table row %0d predicts %h, expected %h",
                             i, pending_q[$], plan[i].want);
            end
        end

        // random: mostly rising stamp runs with queries inside the span
        t = 48'(1000);
        n = 0;
        while (n < 800)
        begin
            calm = (n >= 300 && n < 400);
            case ($urandom_range(9))
                0:       it = rand_item(48'({$urandom, $urandom}),
                                        1'($urandom_range(1)));
                1, 2, 3: it = rand_item(t - 48'($urandom_range(3000)), MODE_QUERY);
                default:
                begin
                    if ($urandom_range(7) != 0)
                        t = t + 48'($urandom_range(n < 700 ? 500 : 100000));
                    it = rand_item(t, MODE_RECORD);
                end
            endcase
            if ($urandom_range(49) == 0)
                it.pos_x = {$urandom_range(1) ? 24'h7FFFFF : 24'h800000};
            send(it);
            n++;
        end
        item_valid <= 1'b0;
        calm = 1'b0;

        quiet = 0;
        while (pending_q.size() != 0 && quiet < 100000)
        begin
            @(posedge clk);
            quiet++;
        end
        repeat (100) @(posedge clk);

        if (mismatches == 0 && unexpected == 0 && pending_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* timestamped_position_history_interp.f */
design/tphi_pkg.sv
design/tphi_ram.sv
design/tphi_front.sv
design/tphi_back.sv
design/timestamped_position_history_interp.sv
verif/timestamped_position_history_interp_tb.sv
